// ----- rtl/sbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_pkg: shared types and constants for the stack bytecode executor
// Instruction codes, result status codes and the decoded instruction record.
// ----------------------------------------------------------------------------
package sbe_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int VAR_COUNT   = 26;
	localparam int DATA_WIDTH  = 32;

	localparam int SP_W  = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int VI_W  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
	localparam int QDEPTH = 2;

	localparam logic [3:0] K_PUSH  = 4'd0;
	localparam logic [3:0] K_STORE = 4'd1;
	localparam logic [3:0] K_LOAD  = 4'd2;
	localparam logic [3:0] K_ADD   = 4'd3;
	localparam logic [3:0] K_SUB   = 4'd4;
	localparam logic [3:0] K_MUL   = 4'd5;
	localparam logic [3:0] K_DIV   = 4'd6;
	localparam logic [3:0] K_PRINT = 4'd7;
	localparam logic [3:0] K_HALT  = 4'd8;

	localparam logic [2:0] ST_PRINTED   = 3'd0;
	localparam logic [2:0] ST_DIVZERO   = 3'd1;
	localparam logic [2:0] ST_HALTED    = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_UNDERFLOW = 3'd4;
	localparam logic [2:0] ST_BADINDEX  = 3'd5;

	// Decoded instruction handed from front to back.
	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] operand;
		logic       bad_index;
	} instr_t;

endpackage

// ----- rtl/sbe_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_ram: generic single-port-write, single-port-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/sbe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_front: instruction intake and classification
// Accepts instructions, drops unused kinds, flags bad variable indexes and
// queues the rest for the execution side.
// ----------------------------------------------------------------------------
module sbe_front
	import sbe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       stall,
	input  logic [3:0] kind,
	input  logic [7:0] operand,
	output logic       q_valid,
	output instr_t     q_data,
	input  logic       q_pop
);
	instr_t           fifo_q [QDEPTH];
	logic [0:0]       wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             push;
	instr_t           dec;

	assign stall   = (cnt_q == 2'(QDEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = fifo_q[rp_q];

	always_comb begin
		dec.kind      = kind;
		dec.operand   = operand;
		dec.bad_index = ({1'b0, operand} >= 9'(VAR_COUNT));
	end

	// Unused kinds are dropped at intake.
	assign push = valid && !stall && (kind <= K_HALT);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QDEPTH))
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !stall && kind > K_HALT) |=> $stable(cnt_q) || $past(q_pop))
		else $error("unused kind entered queue");
endmodule

// ----- rtl/sbe_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_div: signed truncating divider
// Restoring division, one quotient bit per cycle, signs fixed at the end.
// ----------------------------------------------------------------------------
module sbe_div
	import sbe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] q
);
	localparam int BW = $clog2(DATA_WIDTH + 1);
	logic [DATA_WIDTH-1:0] dvd_q, dvs_q, quo_q;
	logic [DATA_WIDTH:0]   rem_q, trial;
	logic [BW-1:0]         n_q;
	logic                  neg_q, busy_q;

	assign trial = {rem_q[DATA_WIDTH-1:0], dvd_q[DATA_WIDTH-1]} - {1'b0, dvs_q};
	assign q     = neg_q ? (DATA_WIDTH'(0) - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			n_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= BW'(DATA_WIDTH);
			end else if (busy_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == BW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= a[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - a) : a;
			dvs_q <= b[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - b) : b;
			neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_WIDTH-2:0], 1'b0};
			if (!trial[DATA_WIDTH]) begin
				rem_q <= trial;
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_WIDTH-1:0], dvd_q[DATA_WIDTH-1]};
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> n_q != '0)
		else $error("divider count underran");
endmodule

// ----- rtl/sbe_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_back: instruction execution
// Runs queued instructions against the stack and variables, emits results.
// ----------------------------------------------------------------------------
module sbe_back
	import sbe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  instr_t              q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  value,
	output logic [2:0]          status
);
	typedef enum logic [2:0] {S_IDLE, S_RD, S_RD2, S_EXEC, S_DIV} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  skip_q;
	logic [DATA_WIDTH-1:0] vars_q [VAR_COUNT];
	logic [DATA_WIDTH-1:0] top_q;
	instr_t                cur_q;
	logic [VI_W-1:0]       vidx;
	logic                  out_free;

	logic                  ram_we;
	logic [SP_W-1:0]       ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	logic                  div_start, div_done;
	logic [DATA_WIDTH-1:0] div_q;

	assign vidx     = cur_q.operand[VI_W-1:0];
	assign out_free = !out_valid || !out_stall;

	sbe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	sbe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .a(ram_rdata), .b(top_q),
		.done(div_done), .q(div_q)
	);

	function automatic logic [31:0] to_out(input logic [DATA_WIDTH-1:0] v);
		logic [63:0] s;
		s = 64'(signed'(v));
		return s[31:0];
	endfunction

	// Pick the read address for the next stack access; hold the second
	// operand address through S_RD and S_RD2 so its read data is ready during execution.
	always_comb begin
		ram_raddr = '0;
		case (state_q)
			S_IDLE: ram_raddr = SP_W'(cnt_q - 1'b1);
			S_RD, S_RD2: ram_raddr = SP_W'(cnt_q - 2'd2);
			default: ram_raddr = '0;
		endcase
	end

	// Write port: pushes, loads and binary results; also the queue pop and divider start.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = SP_W'(cnt_q);
		ram_wdata = '0;
		q_pop     = 1'b0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
				end
			end
			S_RD2: begin
				div_start = (cur_q.kind == K_DIV);
			end
			S_EXEC: begin
				ram_waddr = SP_W'(cnt_q - 2'd2);
				ram_we    = 1'b1;
				case (cur_q.kind)
					K_ADD:   ram_wdata = ram_rdata + top_q;
					K_SUB:   ram_wdata = ram_rdata - top_q;
					default: ram_wdata = DATA_WIDTH'(ram_rdata * top_q);
				endcase
			end
			S_DIV: begin
				ram_waddr = SP_W'(cnt_q - 2'd2);
				ram_we    = div_done;
				ram_wdata = div_q;
			end
			default: ;
		endcase
		// Drop the write on overflow or a bad load index.
		if (state_q == S_RD && (cur_q.kind == K_PUSH || cur_q.kind == K_LOAD)) begin
			ram_waddr = SP_W'(cnt_q);
			ram_we    = (cnt_q != CNT_W'(STACK_DEPTH)) &&
				!(cur_q.kind == K_LOAD && cur_q.bad_index);
			ram_wdata = (cur_q.kind == K_PUSH) ? DATA_WIDTH'(cur_q.operand) : vars_q[vidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			skip_q    <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < VAR_COUNT; i++) vars_q[i] <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						cur_q <= q_data;
						if (q_data.kind == K_HALT) begin
							skip_q    <= 1'b0;
							out_valid <= 1'b1;
							status    <= ST_HALTED;
							value     <= '0;
						end else if (!skip_q) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_IDLE;
					top_q   <= ram_rdata;
					case (cur_q.kind)
						K_PUSH, K_LOAD: begin
							if (cur_q.kind == K_LOAD && cur_q.bad_index) begin
								skip_q <= 1'b1; out_valid <= 1'b1;
								status <= ST_BADINDEX; value <= '0;
							end else if (cnt_q == CNT_W'(STACK_DEPTH)) begin
								skip_q <= 1'b1; out_valid <= 1'b1;
								status <= ST_OVERFLOW; value <= '0;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						K_STORE: begin
							if (cur_q.bad_index) begin
								skip_q <= 1'b1; out_valid <= 1'b1;
								status <= ST_BADINDEX; value <= '0;
							end else if (cnt_q == '0) begin
								skip_q <= 1'b1; out_valid <= 1'b1;
								status <= ST_UNDERFLOW; value <= '0;
							end else begin
								vars_q[vidx] <= ram_rdata;
								cnt_q        <= cnt_q - 1'b1;
							end
						end
						K_PRINT: begin
							out_valid <= 1'b1;
							value     <= '0;
							if (cnt_q == '0) begin
								skip_q <= 1'b1;
								status <= ST_UNDERFLOW;
							end else begin
								status <= ST_PRINTED;
								value  <= to_out(ram_rdata);
								cnt_q  <= cnt_q - 1'b1;
							end
						end
						default: begin
							if (cnt_q < CNT_W'(2)) begin
								skip_q <= 1'b1; out_valid <= 1'b1;
								status <= ST_UNDERFLOW; value <= '0;
							end else if (cur_q.kind == K_DIV && ram_rdata == '0) begin
								skip_q <= 1'b1; out_valid <= 1'b1;
								status <= ST_DIVZERO; value <= '0;
							end else begin
								state_q <= S_RD2;
							end
						end
					endcase
				end
				S_RD2: begin
					state_q <= (cur_q.kind == K_DIV) ? S_DIV : S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					cnt_q   <= cnt_q - 1'b1;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_IDLE;
						cnt_q   <= cnt_q - 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> state_q == S_IDLE)
		else $error("pop while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_PRINTED) |-> value == '0)
		else $error("nonzero value on status result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_HALTED) |-> !skip_q)
		else $error("halt did not clear skipping");
endmodule

// ----- rtl/stack_bytecode_executor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_executor: stack machine instruction executor
// Executes one bytecode instruction per transaction on an operand stack with
// a bank of variable registers, reporting prints, halts and errors.
// ----------------------------------------------------------------------------
// Channel | Signals                        | Direction
// input   | valid, stall, kind, operand    | in (stall out)
// output  | out_valid, out_stall, value,   | out (out_stall in)
//         | status                         |
//
// Push/load/store/print run through S_RD in the executor; add/sub/mul run
// through S_RD, S_RD2 and S_EXEC; div through S_RD, S_RD2 and S_DIV.
// Halt and skipped instructions retire in S_IDLE. A two-entry queue decouples
// intake from execution. Reset clears stack count, variables and skipping.
// A stalled result holds; the executor waits for a free output register.
// ----------------------------------------------------------------------------
module stack_bytecode_executor
	import sbe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  logic [3:0]         kind,
	input  logic [7:0]         operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic [2:0]         status
);
	// Queue between the front and back halves.
	logic   q_valid, q_pop;
	instr_t q_data;

	// Classify and buffer incoming instructions.
	sbe_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.kind(kind), .operand(operand),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	// Execute against the stack and emit results.
	sbe_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.value(value), .status(status)
	);
endmodule

// ----- tb/sv/tb_stack_bytecode_executor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_bytecode_executor: self-checking bench for the bytecode executor
// Walks a directed table of instructions, then random well-formed programs
// mixed with noise. A behavioral model of the operand stack and variables
// predicts each result; results are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_stack_bytecode_executor;
	import sbe_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               valid;
	logic               stall;
	logic [3:0]         kind;
	logic [7:0]         operand;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] value;
	logic [2:0]         status;

	typedef struct {
		logic [31:0] value;
		logic [2:0]  status;
	} result_t;

	// Directed row: instruction plus an optional typed-in expectation.
	typedef struct {
		logic [3:0]  kind;
		logic [7:0]  operand;
		bit          typed;
		bit          has_res;
		logic [31:0] value;
		logic [2:0]  status;
	} row_t;

	// Predictor state
	logic [DATA_WIDTH-1:0] stk [STACK_DEPTH];
	int                    depth;
	logic [DATA_WIDTH-1:0] vars [VAR_COUNT];
	bit                    skip_mode;

	result_t pending_results[$];
	int      errors;
	int      n_items;
	int      n_results;
	bit      in_quiet;
	bit      out_quiet;
	bit      driving_done;

	stack_bytecode_executor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.stall     (stall),
		.kind      (kind),
		.operand   (operand),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Signed truncating divide at DATA_WIDTH; most-negative / -1 wraps.
	function automatic logic [DATA_WIDTH-1:0] quotient(logic [DATA_WIDTH-1:0] a,
			logic [DATA_WIDTH-1:0] b);
		logic [DATA_WIDTH-1:0] ua;
		logic [DATA_WIDTH-1:0] ub;
		logic [DATA_WIDTH-1:0] q;
		ua = a[DATA_WIDTH-1] ? -a : a;
		ub = b[DATA_WIDTH-1] ? -b : b;
		q = ua / ub;
		return (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) ? -q : q;
	endfunction

	// Execute one instruction on the model; return 1 when a result is due.
	function automatic bit execute(logic [3:0] k, logic [7:0] opd, output result_t r);
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
		r.value = '0;
		r.status = ST_PRINTED;
		if (k == K_HALT) begin
			skip_mode = 1'b0;
			r.status = ST_HALTED;
			return 1'b1;
		end
		if (skip_mode || k > K_HALT)
			return 1'b0;
		r.status = ST_UNDERFLOW;
		case (k)
			K_PUSH: begin
				if (depth >= STACK_DEPTH) begin
					r.status = ST_OVERFLOW;
				end else begin
					stk[depth] = DATA_WIDTH'(opd);
					depth++;
					return 1'b0;
				end
			end
			K_STORE: begin
				if (opd >= VAR_COUNT) begin
					r.status = ST_BADINDEX;
				end else if (depth != 0) begin
					depth--;
					vars[opd] = stk[depth];
					return 1'b0;
				end
			end
			K_LOAD: begin
				if (opd >= VAR_COUNT) begin
					r.status = ST_BADINDEX;
				end else if (depth >= STACK_DEPTH) begin
					r.status = ST_OVERFLOW;
				end else begin
					stk[depth] = vars[opd];
					depth++;
					return 1'b0;
				end
			end
			K_PRINT: begin
				if (depth != 0) begin
					depth--;
					r.status = ST_PRINTED;
					r.value = 32'(signed'(stk[depth]));
					return 1'b1;
				end
			end
			default: begin
				if (depth >= 2) begin
					a = stk[depth-2];
					b = stk[depth-1];
					if (k == K_DIV && b == '0) begin
						r.status = ST_DIVZERO;
					end else begin
						case (k)
							K_ADD:   stk[depth-2] = a + b;
							K_SUB:   stk[depth-2] = a - b;
							K_MUL:   stk[depth-2] = a * b;
							default: stk[depth-2] = quotient(a, b);
						endcase
						depth--;
						return 1'b0;
					end
				end
			end
		endcase
		skip_mode = 1'b1;
		return 1'b1;
	endfunction

	// Hand one instruction to the block; predict at acceptance.
	// Valid stays high after acceptance until the next transaction or an idle.
	task automatic send(logic [3:0] k, logic [7:0] opd, output result_t r, output bit got);
		while (!in_quiet && $urandom_range(99) < 14) begin
			valid <= 1'b0;
			@(negedge clk);
		end
		valid   <= 1'b1;
		kind    <= k;
		operand <= opd;
		@(posedge clk);
		while (stall)
			@(posedge clk);
		got = execute(k, opd, r);
		if (got)
			pending_results.push_back(r);
		n_items++;
		@(negedge clk);
	endtask

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: value %0d status %0d", value, status);
				errors++;
			end else begin
				result_t e;
				e = pending_results.pop_front();
				n_results++;
				if (value !== e.value) begin
					$error("value: expected %0d actual %0d", $signed(e.value), value);
					errors++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, status);
					errors++;
				end
			end
		end
	end

	// Receiver stall, quiet while out_quiet is set.
	always @(negedge clk)
		out_stall <= (!out_quiet && $urandom_range(99) < 14);

	// Fill a random well-formed program: pushes and loads, ops, print, halt.
	task automatic run_program();
		result_t r;
		bit      got;
		int      len;
		len = $urandom_range(4, 14);
		for (int i = 0; i < len; i++) begin
			if (depth < 2 || $urandom_range(2) == 0) begin
				if ($urandom_range(3) == 0)
					send(K_LOAD, 8'($urandom_range(VAR_COUNT - 1)), r, got);
				else
					send(K_PUSH, 8'($urandom), r, got);
			end else begin
				case ($urandom_range(5))
					0: send(K_ADD, 8'($urandom), r, got);
					1: send(K_SUB, 8'($urandom), r, got);
					2: send(K_MUL, 8'($urandom), r, got);
					3: send(K_DIV, 8'($urandom), r, got);
					4: send(K_STORE, 8'($urandom_range(VAR_COUNT - 1)), r, got);
					default: send(K_PRINT, 8'($urandom), r, got);
				endcase
			end
		end
		while (depth > 0 && $urandom_range(3) != 0)
			send(K_PRINT, 8'($urandom), r, got);
		if ($urandom_range(2) == 0)
			send(K_HALT, 8'($urandom), r, got);
	endtask

	initial begin
		row_t    rows[$];
		result_t r;
		bit      got;
		valid     = 1'b0;
		kind      = '0;
		operand   = '0;
		out_stall = 1'b0;
		errors    = 0;
		n_items   = 0;
		n_results = 0;
		in_quiet  = 1'b0;
		out_quiet = 1'b0;
		driving_done = 1'b0;
		depth     = 0;
		skip_mode = 1'b0;
		foreach (vars[i])
			vars[i] = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		rows = '{
			'{K_PRINT, 8'd0,   1, 1, 32'd0, ST_UNDERFLOW},  // empty stack
			'{K_PUSH,  8'd1,   1, 0, 32'd0, ST_PRINTED},    // skipped
			'{K_HALT,  8'd0,   1, 1, 32'd0, ST_HALTED},
			'{K_LOAD,  8'd25,  0, 0, 32'd0, ST_PRINTED},    // variable cleared at reset
			'{K_PRINT, 8'd0,   1, 1, 32'd0, ST_PRINTED},
			'{K_PUSH,  8'd255, 0, 0, 32'd0, ST_PRINTED},
			'{K_PRINT, 8'd0,   1, 1, 32'd255, ST_PRINTED},
			'{K_LOAD,  8'd26,  1, 1, 32'd0, ST_BADINDEX},
			'{K_HALT,  8'd0,   1, 1, 32'd0, ST_HALTED},
			'{K_STORE, 8'd255, 1, 1, 32'd0, ST_BADINDEX},  // index before underflow
			'{K_HALT,  8'd0,   1, 1, 32'd0, ST_HALTED},
			'{K_PUSH,  8'd0,   0, 0, 32'd0, ST_PRINTED},
			'{K_ADD,   8'd0,   1, 1, 32'd0, ST_UNDERFLOW},
			'{K_HALT,  8'd0,   1, 1, 32'd0, ST_HALTED},
			'{K_PUSH,  8'd7,   0, 0, 32'd0, ST_PRINTED},
			'{K_PUSH,  8'd0,   0, 0, 32'd0, ST_PRINTED},
			'{K_DIV,   8'd0,   1, 1, 32'd0, ST_DIVZERO},
			'{4'd15,   8'd0,   1, 0, 32'd0, ST_PRINTED},   // unused kind
			'{K_HALT,  8'd0,   1, 1, 32'd0, ST_HALTED},
			'{K_SUB,   8'd0,   0, 0, 32'd0, ST_PRINTED},   // 7 - 0
			'{K_STORE, 8'd0,   0, 0, 32'd0, ST_PRINTED},
			'{4'd9,    8'd170, 1, 0, 32'd0, ST_PRINTED},
			'{K_PUSH,  8'd85,  0, 0, 32'd0, ST_PRINTED},
			'{K_MUL,   8'd0,   0, 0, 32'd0, ST_PRINTED}
		};
		foreach (rows[i]) begin
			send(rows[i].kind, rows[i].operand, r, got);
			if (rows[i].typed && (got != rows[i].has_res ||
					(got && (r.value !== rows[i].value || r.status !== rows[i].status)))) begin
				$error("table row %0d: predictor disagrees with typed-in result", i);
				errors++;
			end
		end
		send(K_HALT, 8'd0, r, got);

		// Most-negative / -1 wraps: build 0x80000000 from pushes.
		send(K_PUSH, 8'd128, r, got);
		send(K_PUSH, 8'd0, r, got);
		send(K_PUSH, 8'd1, r, got);
		send(K_SUB, 8'd0, r, got);     // -1
		send(K_STORE, 8'd1, r, got);
		send(K_PUSH, 8'd255, r, got);
		send(K_PUSH, 8'd1, r, got);
		send(K_ADD, 8'd0, r, got);     // 256
		send(K_STORE, 8'd2, r, got);
		for (int i = 0; i < 3; i++) begin
			send(K_LOAD, 8'd2, r, got);
			send(K_MUL, 8'd0, r, got);
		end
		send(K_LOAD, 8'd1, r, got);
		send(K_DIV, 8'd0, r, got);
		send(K_PRINT, 8'd0, r, got);

		// Fill the stack to overflow, then drain it.
		while (depth < STACK_DEPTH)
			send(K_PUSH, 8'($urandom), r, got);
		send(K_LOAD, 8'd3, r, got);
		send(K_HALT, 8'd0, r, got);
		while (depth > 0)
			send(K_PRINT, 8'd0, r, got);

		// Random programs; one long stretch without idling on either side.
		while (n_items < 750) begin
			in_quiet  = (n_items > 400 && n_items < 550);
			out_quiet = in_quiet;
			if ($urandom_range(9) < 8) begin
				run_program();
			end else begin
				send(4'($urandom), 8'($urandom), r, got);
			end
		end
		valid     <= 1'b0;
		in_quiet  = 1'b0;
		out_quiet = 1'b0;
		driving_done = 1'b1;
	end

	initial begin
		wait (driving_done);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d instructions issued, %0d results checked", n_items, n_results);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule
